>>> rtl/fiews_pkg.sv
// shared constants for the frame interval moving mean and variance block
`default_nettype none

package fiews_pkg;

	// defaults for the top level parameters
	localparam int TIME_BITS_DEF     = 48;
	localparam int FRACTION_BITS_DEF = 8;

	// field widths fixed by the interface
	localparam int WEIGHT_W = 16;
	localparam int COUNT_W  = 32;
	localparam int MEAN_W   = 24;
	localparam int VAR_W    = 48;
	localparam int DT_W     = 16;
	localparam int DTF_W    = 32;

	// shared multiplier: signed operands, full width product
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// squared deviation stays below 2^60 for any fraction width of at least 4
	localparam int S_W     = 60;
	localparam int CHUNK_T = 30;
	// variance plus weighted square stays below 2^62
	localparam int SUM_W   = 62;
	localparam int CHUNK_V = 31;
	// accumulator for the split q16 products
	localparam int ACC_W   = 80;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd10879;
	localparam logic [WEIGHT_W:0]   ONE_Q16      = 17'd65536;
	localparam logic [ACC_W-1:0]    ROUND_Q16    = 80'd32768;
	localparam logic [MEAN_W-1:0]   MEAN_MAX     = {MEAN_W{1'b1}};
	localparam logic [VAR_W-1:0]    VAR_MAX      = {VAR_W{1'b1}};
	localparam logic [DT_W-1:0]     DT_MAX       = {DT_W{1'b1}};

endpackage

`default_nettype wire

>>> rtl/frame_interval_ewma_stats.sv
// top level: frame interval moving mean and variance with one shared multiplier
`default_nettype none

// Each input transfer is one frame present stamped in milliseconds. The block counts
// presents (wrapping at 2^32), keeps the last stamp, and when that stamp is nonzero
// updates a moving mean and variance of the interval using weight smoothing_weight
// (Q0.16); the interval saturates at 65535 ms, mean and variance carry FRACTION_BITS
// fraction bits and the variance saturates at 2^48-1. All products go through one
// signed 33 x 33 multiplier under a small sequencer, so an updating present runs six
// multiplies plus the rounding, accumulate and saturate steps around them before its
// result is loaded into the output register, and the next present is taken only once
// that result is loaded; a present with no stored stamp goes straight to that load.
// in_ready is low from the input transfer until the result has been loaded into the
// output register; a result held there does not block the next input. The weight
// register may only be written while no present is in progress.

module frame_interval_ewma_stats #(
	parameter int TIME_BITS     = fiews_pkg::TIME_BITS_DEF,
	parameter int FRACTION_BITS = fiews_pkg::FRACTION_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_wr_en,
	input  wire  [fiews_pkg::WEIGHT_W-1:0]        cfg_wr_data,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  [TIME_BITS-1:0]                  present_time_ms,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [fiews_pkg::COUNT_W-1:0]         frames_seen,
	output logic [fiews_pkg::MEAN_W-1:0]          mean_interval,
	output logic [fiews_pkg::VAR_W-1:0]           interval_variance,
	output logic                                  stats_updated
);

	localparam int ACC_W  = fiews_pkg::ACC_W;
	localparam int PROD_W = fiews_pkg::PROD_W;
	localparam int MUL_W  = fiews_pkg::MUL_W;
	localparam int SUM_W  = fiews_pkg::SUM_W;
	localparam int S_W    = fiews_pkg::S_W;
	localparam int VAR_W  = fiews_pkg::VAR_W;
	localparam int MEAN_W = fiews_pkg::MEAN_W;
	localparam int DTF_W  = fiews_pkg::DTF_W;
	localparam int DT_W   = fiews_pkg::DT_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_MUL,
		ST_MEAN_UPD,
		ST_SQ_MUL,
		ST_SQ_RND,
		ST_T_LO,
		ST_T_HI,
		ST_T_ADD,
		ST_SUM,
		ST_V_LO,
		ST_V_HI,
		ST_V_ADD,
		ST_V_SAT,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [fiews_pkg::WEIGHT_W-1:0]    weight_q;
	logic [TIME_BITS-1:0]              prev_q;
	logic [fiews_pkg::COUNT_W-1:0]     count_q;
	logic [MEAN_W-1:0]                 mean_q;
	logic [VAR_W-1:0]                  var_q;
	logic                              upd_q;
	logic                              out_valid_q;
	logic [fiews_pkg::COUNT_W-1:0]     frames_out_q;
	logic [MEAN_W-1:0]                 mean_out_q;
	logic [VAR_W-1:0]                  var_out_q;
	logic                              upd_out_q;

	// datapath registers, no reset
	logic [DTF_W-1:0]                  dtf_q;
	logic [S_W-1:0]                    s_q;
	logic [SUM_W-1:0]                  sum_q;
	logic [ACC_W-1:0]                  acc_q;

	logic                              in_xfer;
	logic                              out_free;
	logic [TIME_BITS-1:0]              dt_full;
	logic [DT_W-1:0]                   dt_sat;
	logic [DTF_W-1:0]                  dtf_next;
	logic [fiews_pkg::WEIGHT_W:0]      one_minus_w;
	logic signed [MUL_W-1:0]           diff;
	logic [MUL_W-1:0]                  abs_diff;
	logic signed [MUL_W-1:0]           mul_a;
	logic signed [MUL_W-1:0]           mul_b;
	logic                              mul_en;
	logic signed [PROD_W-1:0]          prod;
	logic signed [PROD_W-1:0]          mean_inc;
	logic signed [PROD_W-1:0]          mean_sum;
	logic [MEAN_W-1:0]                 mean_next;
	logic [PROD_W-3:0]                 sq_rnd;
	logic [ACC_W-1:0]                  prod_ext;
	logic [ACC_W-VAR_W-17:0]           var_hi;
	logic [VAR_W-1:0]                  var_next;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// interval from the stored stamp, saturated to 16 bits
	always_comb begin
		dt_full  = present_time_ms - prev_q;
		dt_sat   = (|dt_full[TIME_BITS-1:DT_W]) ? fiews_pkg::DT_MAX : dt_full[DT_W-1:0];
		dtf_next = DTF_W'(dt_sat) << FRACTION_BITS;
	end

	// deviation of the scaled interval from the current mean
	always_comb begin
		one_minus_w = fiews_pkg::ONE_Q16 - {1'b0, weight_q};
		diff        = $signed({1'b0, dtf_q}) - $signed({(MUL_W-MEAN_W)'(0), mean_q});
		abs_diff    = diff[MUL_W-1] ? MUL_W'(-diff) : MUL_W'(diff);
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_MEAN_MUL: begin
				mul_a = $signed({(MUL_W-fiews_pkg::WEIGHT_W)'(0), weight_q});
				mul_b = diff;
			end
			ST_SQ_MUL: begin
				mul_a = $signed(abs_diff);
				mul_b = $signed(abs_diff);
			end
			ST_T_LO: begin
				mul_a = $signed({(MUL_W-fiews_pkg::WEIGHT_W)'(0), weight_q});
				mul_b = $signed({(MUL_W-fiews_pkg::CHUNK_T)'(0),
					s_q[fiews_pkg::CHUNK_T-1:0]});
			end
			ST_T_HI: begin
				mul_a = $signed({(MUL_W-fiews_pkg::WEIGHT_W)'(0), weight_q});
				mul_b = $signed({(MUL_W-(S_W-fiews_pkg::CHUNK_T))'(0),
					s_q[S_W-1:fiews_pkg::CHUNK_T]});
			end
			ST_V_LO: begin
				mul_a = $signed({(MUL_W-fiews_pkg::WEIGHT_W-1)'(0), one_minus_w});
				mul_b = $signed({(MUL_W-fiews_pkg::CHUNK_V)'(0),
					sum_q[fiews_pkg::CHUNK_V-1:0]});
			end
			ST_V_HI: begin
				mul_a = $signed({(MUL_W-fiews_pkg::WEIGHT_W-1)'(0), one_minus_w});
				mul_b = $signed({(MUL_W-(SUM_W-fiews_pkg::CHUNK_V))'(0),
					sum_q[SUM_W-1:fiews_pkg::CHUNK_V]});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	fiews_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod)
	);

	// rounded mean step, clamped to the mean range
	always_comb begin
		mean_inc = (prod + PROD_W'(signed'(32768))) >>> 16;
		mean_sum = $signed({(PROD_W-MEAN_W)'(0), mean_q}) + mean_inc;
		if (mean_sum[PROD_W-1]) begin
			mean_next = '0;
		end else if (|mean_sum[PROD_W-2:MEAN_W]) begin
			mean_next = fiews_pkg::MEAN_MAX;
		end else begin
			mean_next = mean_sum[MEAN_W-1:0];
		end
	end

	// squared deviation rounded to the fraction grid, and variance saturation
	always_comb begin
		sq_rnd   = prod[PROD_W-3:0] + ((PROD_W-2)'(1) << (FRACTION_BITS - 1));
		prod_ext = {(ACC_W-PROD_W)'(0), prod};
		var_hi   = acc_q[ACC_W-1:VAR_W+16];
		var_next = (|var_hi) ? fiews_pkg::VAR_MAX : acc_q[16 +: VAR_W];
	end

	// sequencer, architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			weight_q     <= fiews_pkg::WEIGHT_RESET;
			prev_q       <= '0;
			count_q      <= '0;
			mean_q       <= '0;
			var_q        <= '0;
			upd_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			frames_out_q <= '0;
			mean_out_q   <= '0;
			var_out_q    <= '0;
			upd_out_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				weight_q <= cfg_wr_data;
			end
			// a result loaded in the done step replaces the one taken
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						prev_q  <= present_time_ms;
						count_q <= count_q + fiews_pkg::COUNT_W'(1);
						if (prev_q == '0) begin
							upd_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							upd_q   <= 1'b1;
							state_q <= ST_MEAN_MUL;
						end
					end
				end
				ST_MEAN_MUL: state_q <= ST_MEAN_UPD;
				ST_MEAN_UPD: begin
					mean_q  <= mean_next;
					state_q <= ST_SQ_MUL;
				end
				ST_SQ_MUL: state_q <= ST_SQ_RND;
				ST_SQ_RND: state_q <= ST_T_LO;
				ST_T_LO:   state_q <= ST_T_HI;
				ST_T_HI:   state_q <= ST_T_ADD;
				ST_T_ADD:  state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_V_LO;
				ST_V_LO:   state_q <= ST_V_HI;
				ST_V_HI:   state_q <= ST_V_ADD;
				ST_V_ADD:  state_q <= ST_V_SAT;
				ST_V_SAT: begin
					var_q   <= var_next;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						frames_out_q <= count_q;
						mean_out_q   <= mean_q;
						var_out_q    <= var_q;
						upd_out_q    <= upd_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// intermediate values of the update
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:   dtf_q <= dtf_next;
			ST_SQ_RND: s_q   <= S_W'(sq_rnd >> FRACTION_BITS);
			ST_T_HI:   acc_q <= prod_ext + fiews_pkg::ROUND_Q16;
			ST_T_ADD:  acc_q <= acc_q + (prod_ext << fiews_pkg::CHUNK_T);
			ST_SUM:    sum_q <= {(SUM_W-VAR_W)'(0), var_q} + acc_q[16 +: SUM_W];
			ST_V_HI:   acc_q <= prod_ext + fiews_pkg::ROUND_Q16;
			ST_V_ADD:  acc_q <= acc_q + (prod_ext << fiews_pkg::CHUNK_V);
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign frames_seen       = frames_out_q;
	assign mean_interval     = mean_out_q;
	assign interval_variance = var_out_q;
	assign stats_updated     = upd_out_q;

endmodule

`default_nettype wire

>>> rtl/fiews_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module fiews_mul (
	input  wire                                   clk,
	input  wire                                   en,
	input  wire  signed [fiews_pkg::MUL_W-1:0]    op_a,
	input  wire  signed [fiews_pkg::MUL_W-1:0]    op_b,
	output logic signed [fiews_pkg::PROD_W-1:0]   prod_q
);

	// product register, loaded only on steps that use the unit
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

`default_nettype wire

>>> rtl/fiews_checker.sv
// port level checks for the frame interval statistics block, bound to the top level
`default_nettype none

module fiews_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire [fiews_pkg::COUNT_W-1:0]       frames_seen,
	input wire [fiews_pkg::MEAN_W-1:0]        mean_interval,
	input wire [fiews_pkg::VAR_W-1:0]         interval_variance,
	input wire                                stats_updated
);

	logic seen_q;

	// marks that a result transfer has happened since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			seen_q <= 1'b1;
		end
	end

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frames_seen)
			&& $stable(mean_interval) && $stable(interval_variance)
			&& $stable(stats_updated))
		else $error("result changed while stalled");

	// the sequencer is busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an update is in progress");

	// first result after reset has no stored stamp to update from
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_q |-> !stats_updated && frames_seen == 32'd1
			&& mean_interval == '0 && interval_variance == '0)
		else $error("first result is not a plain count");

	// back to back results count one present apart
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid
			|| frames_seen == $past(frames_seen) + 32'd1)
		else $error("result count skipped or repeated");

endmodule

bind frame_interval_ewma_stats fiews_checker u_fiews_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.frames_seen       (frames_seen),
	.mean_interval     (mean_interval),
	.interval_variance (interval_variance),
	.stats_updated     (stats_updated)
);

`default_nettype wire

>>> sim/frame_interval_ewma_stats_checker.sv
// watches both channels of the frame interval block, predicts each result and compares it
`timescale 1ns / 100ps

module frame_interval_ewma_stats_checker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_wr_en,
	input  wire  [fiews_pkg::WEIGHT_W-1:0]        cfg_wr_data,
	input  wire                                   in_valid,
	input  wire                                   in_ready,
	input  wire  [fiews_pkg::TIME_BITS_DEF-1:0]   present_time_ms,
	input  wire                                   out_valid,
	input  wire                                   out_ready,
	input  wire  [fiews_pkg::COUNT_W-1:0]         frames_seen,
	input  wire  [fiews_pkg::MEAN_W-1:0]          mean_interval,
	input  wire  [fiews_pkg::VAR_W-1:0]           interval_variance,
	input  wire                                   stats_updated,
	output int                                    pending_results,
	output int                                    error_total
);
	import fiews_pkg::*;

	localparam int TBITS = TIME_BITS_DEF;
	localparam int FBITS = FRACTION_BITS_DEF;

	typedef struct packed {
		logic [COUNT_W-1:0] frames;
		logic [MEAN_W-1:0]  mean;
		logic [VAR_W-1:0]   variance;
		logic               updated;
	} frame_stats_t;

	// predicted results in transfer order
	frame_stats_t stats_q[$];
	frame_stats_t want;

	// own copy of the block state and weight register
	logic [WEIGHT_W-1:0] weight;
	logic [TBITS-1:0]    last_stamp;
	logic [COUNT_W-1:0]  present_tally;
	logic [MEAN_W-1:0]   mean_acc;
	logic [VAR_W-1:0]    var_acc;
	int                  fail_tally;

	// one present: count it, and update mean and variance when a previous stamp exists
	function automatic frame_stats_t advance_frame_stats(input logic [TBITS-1:0] stamp);
		frame_stats_t r;
		logic [TBITS-1:0] span;
		longint a, dtf, diff, step, nm, dev;
		logic [63:0] dev_mag, sq, wsq, vsum;
		logic [95:0] wide;
		logic [WEIGHT_W:0] keep;
		r.updated = 1'b0;
		present_tally = present_tally + 1'b1;
		if (last_stamp != '0) begin
			// interval wraps modulo the stamp width, then saturates
			span = stamp - last_stamp;
			if (span > TBITS'(DT_MAX))
				span = TBITS'(DT_MAX);
			a = longint'(weight);
			dtf = longint'(span) <<< FBITS;
			// mean step, rounded half up also for negative differences
			diff = dtf - longint'(mean_acc);
			step = (a * diff + longint'(32768)) >>> 16;
			nm = longint'(mean_acc) + step;
			if (nm < 0)
				nm = 0;
			else if (nm > longint'(MEAN_MAX))
				nm = longint'(MEAN_MAX);
			mean_acc = MEAN_W'(nm);
			// squared deviation from the new mean
			dev = dtf - nm;
			dev_mag = (dev < 0) ? -dev : dev;
			sq = (dev_mag * dev_mag + (64'd1 << (FBITS - 1))) >> FBITS;
			if (sq > (64'd1 << 61))
				sq = 64'd1 << 61;
			// weighted square, then decay by one minus the weight
			wide = 96'(weight) * 96'(sq) + 96'd32768;
			wsq = 64'(wide >> 16);
			vsum = 64'(var_acc) + wsq;
			keep = ONE_Q16 - weight;
			wide = (96'(keep) * 96'(vsum) + 96'd32768) >> 16;
			var_acc = (wide > 96'(VAR_MAX)) ? VAR_MAX : VAR_W'(wide);
			r.updated = 1'b1;
		end
		last_stamp = stamp;
		r.frames = present_tally;
		r.mean = mean_acc;
		r.variance = var_acc;
		return r;
	endfunction

	// follow register writes and both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight = WEIGHT_RESET;
			last_stamp = '0;
			present_tally = '0;
			mean_acc = '0;
			var_acc = '0;
			fail_tally = 0;
			stats_q.delete();
			pending_results <= 0;
			error_total <= 0;
		end else begin
			if (cfg_wr_en)
				weight = cfg_wr_data;

			// result transfer against the oldest prediction
			if (out_valid && out_ready) begin
				if (stats_q.size() == 0) begin
					$error("result transfer with nothing outstanding, frames_seen %0d", frames_seen);
					fail_tally++;
				end else begin
					want = stats_q.pop_front();
					if (frames_seen !== want.frames) begin
						$error("frames_seen: expected %0d, got %0d", want.frames, frames_seen);
						fail_tally++;
					end
					if (mean_interval !== want.mean) begin
						$error("mean_interval: expected %0d, got %0d", want.mean, mean_interval);
						fail_tally++;
					end
					if (interval_variance !== want.variance) begin
						$error("interval_variance: expected %0d, got %0d",
							want.variance, interval_variance);
						fail_tally++;
					end
					if (stats_updated !== want.updated) begin
						$error("stats_updated: expected %0d, got %0d", want.updated, stats_updated);
						fail_tally++;
					end
				end
			end

			// present transfer
			if (in_valid && in_ready)
				stats_q.push_back(advance_frame_stats(present_time_ms));

			pending_results <= stats_q.size();
			error_total <= fail_tally;
		end
	end

endmodule

>>> sim/frame_interval_ewma_stats_tb.sv
// testbench top for the frame interval moving mean and variance block
`timescale 1ns / 100ps

module frame_interval_ewma_stats_tb;
	import fiews_pkg::*;

	localparam int TBITS       = TIME_BITS_DEF;
	localparam int OPENING_N   = 20;
	localparam int PHASE_N     = 8;
	localparam int PHASE_ITEMS = 222;
	localparam int LONG_HOLD   = 400;

	typedef enum logic [1:0] {PACE_FULL, PACE_TX_SPARSE, PACE_RX_SPARSE, PACE_BOTH_LIGHT} pace_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [WEIGHT_W-1:0] cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	wire                 in_ready;
	logic [TBITS-1:0]    present_time_ms = '0;
	wire                 out_valid;
	logic                out_ready = 1'b0;
	wire [COUNT_W-1:0]   frames_seen;
	wire [MEAN_W-1:0]    mean_interval;
	wire [VAR_W-1:0]     interval_variance;
	wire                 stats_updated;
	int                  pending_results;
	int                  error_total;

	pace_t               pace = PACE_FULL;
	logic                hold_toggle = 1'b0;
	logic                hold_seen = 1'b0;
	int                  hold_left = 0;

	logic [TBITS-1:0]    stamp_now;
	logic [TBITS-1:0]    next_stamp;
	logic [TBITS-1:0]    opening_stamps [OPENING_N];
	logic [WEIGHT_W-1:0] phase_weight;
	int                  presents_sent = 0;
	int                  period_ms;
	int                  roll;

	frame_interval_ewma_stats dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.present_time_ms   (present_time_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.frames_seen       (frames_seen),
		.mean_interval     (mean_interval),
		.interval_variance (interval_variance),
		.stats_updated     (stats_updated)
	);

	frame_interval_ewma_stats_checker interval_stats_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.present_time_ms   (present_time_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.frames_seen       (frames_seen),
		.mean_interval     (mean_interval),
		.interval_variance (interval_variance),
		.stats_updated     (stats_updated),
		.pending_results   (pending_results),
		.error_total       (error_total)
	);

	always #5 clk = ~clk;

	// result side: random stalls by pace, plus one long hold on request
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			case (pace)
				PACE_RX_SPARSE: begin
					out_ready <= ($urandom_range(99) >= 83);
				end
				PACE_BOTH_LIGHT: begin
					out_ready <= ($urandom_range(99) >= 15);
				end
				default: begin
					out_ready <= 1'b1;
				end
			endcase
		end
	end

	// offer one present and wait for its transfer
	task automatic offer_present(input logic [TBITS-1:0] stamp);
		int idle_pct;
		idle_pct = (pace == PACE_TX_SPARSE) ? 83 : (pace == PACE_BOTH_LIGHT) ? 15 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		present_time_ms <= stamp;
		do @(posedge clk); while (!in_ready);
		presents_sent++;
	endtask

	// drop valid and wait until every predicted result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_weight(input logic [WEIGHT_W-1:0] w);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		// first stamp, wrap, exact and over-limit intervals, backward step, zero stamps
		opening_stamps = '{48'd5, 48'd21, 48'd37, 48'd54, 48'd0, 48'd7, 48'd7,
			48'hFFFF_FFFF_FFFF, 48'd10, 48'd65545, 48'd131081, 48'd431081, 48'd431076,
			48'd431092, 48'd431108, 48'd431125, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
			48'h8000_0000_0010, 48'h8000_0000_0020};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed presents at the reset weight
		for (int i = 0; i < OPENING_N; i++)
			offer_present(opening_stamps[i]);
		stamp_now = opening_stamps[OPENING_N-1];

		// random phases, each with its own weight and pacing
		for (int p = 0; p < PHASE_N; p++) begin
			settle();
			case (p)
				0: phase_weight = '0;
				1: phase_weight = '1;
				2: phase_weight = 16'd1;
				3: phase_weight = 16'h8000;
				4: phase_weight = WEIGHT_RESET;
				default: phase_weight = WEIGHT_W'($urandom_range(65535));
			endcase
			pace <= pace_t'(p % 4);
			// long output hold while presents keep coming at full rate
			if (p == 4)
				hold_toggle <= ~hold_toggle;
			write_weight(phase_weight);
			period_ms = $urandom_range(70, 4);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(99);
				if (roll < 78)
					stamp_now = stamp_now + period_ms + $urandom_range(7);
				else if (roll < 82)
					stamp_now = stamp_now + $urandom_range(400);
				else if (roll < 87)
					stamp_now = stamp_now + $urandom_range(140000, 60000);
				else if (roll < 91)
					stamp_now = stamp_now - $urandom_range(2000, 1);
				else if (roll >= 94)
					stamp_now = TBITS'({$urandom, $urandom});
				next_stamp = (roll >= 91 && roll < 94) ? '0 : stamp_now;
				offer_present(next_stamp);
			end
		end
		settle();

		$display("%0d presents checked over %0d weight settings, weight extremes included,",
			presents_sent, PHASE_N + 1);
		$display("with sparse and stalled handshakes and one long output hold");
		if (error_total == 0 && pending_results == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
